[hdl/ordered_slot_list_insert_remove_defines.svh]
// Assertion macros for the ordered slot list block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef ORDERED_SLOT_LIST_INSERT_REMOVE_DEFINES_SVH
`define ORDERED_SLOT_LIST_INSERT_REMOVE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OSL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define OSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/osl_pkg.sv]
// Shared constants, status codes and types for the ordered slot list.
// No dependencies.
`default_nettype none

package osl_pkg;

  localparam int CAPACITY = 8;
  localparam int ID_W     = 16;
  localparam int STATUS_W = 3;
  localparam int OCC_W    = 4;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam logic OP_DEPART = 1'b0;
  localparam logic OP_ARRIVE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_STORED  = 3'd0,
    ST_PRESENT = 3'd1,
    ST_FULL    = 3'd2,
    ST_REMOVED = 3'd3,
    ST_ABSENT  = 3'd4
  } status_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [ID_W-1:0]  wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

[hdl/osl_slot_mem.sv]
// Slot storage: one write port and one registered read port.
// Depends on osl_pkg.
`default_nettype none

module osl_slot_mem
  import osl_pkg::*;
(
  input  wire logic            clk,
  input  wire mem_req_t        req,
  output logic [ID_W-1:0]      rd_data
);

  logic [ID_W-1:0] mem [CAPACITY];
  logic [ID_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[hdl/osl_ctrl.sv]
// Sequencer for search, append and shift-down over the slot memory,
// with the result output register. Depends on osl_pkg.
`default_nettype none

module osl_ctrl
  import osl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_operation,
  input  wire logic [ID_W-1:0]     in_item_id,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [OCC_W-1:0]         out_occupancy,
  output mem_req_t                 mem_req,
  input  wire logic [ID_W-1:0]     mem_rd_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_CMP  = 6'b000100,
    S_SHRD = 6'b001000,
    S_SHWR = 6'b010000,
    S_RESP = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     scan_r, scan_nxt;
  logic                 op_r, op_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  status_t              status_r, status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [OCC_W-1:0]     out_occ_r, out_occ_nxt;
  logic [CNT_W-1:0]     scan_inc;
  logic                 out_free;

  assign scan_inc = scan_r + CNT_W'(1);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    scan_nxt       = scan_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    mem_req        = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_operation;
          id_nxt   = in_item_id;
          scan_nxt = '0;
          if (in_operation == OP_ARRIVE && count_r >= CNT_W'(CAPACITY)) begin
            status_nxt = ST_FULL;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        if (scan_r < count_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = scan_r[IDX_W-1:0];
          state_nxt     = S_CMP;
        end else if (op_r == OP_ARRIVE) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = count_r[IDX_W-1:0];
          mem_req.wdata = id_r;
          count_nxt     = count_r + CNT_W'(1);
          status_nxt    = ST_STORED;
          state_nxt     = S_RESP;
        end else begin
          status_nxt = ST_ABSENT;
          state_nxt  = S_RESP;
        end
      end
      S_CMP: begin
        if (mem_rd_data == id_r) begin
          if (op_r == OP_ARRIVE) begin
            status_nxt = ST_PRESENT;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_SHRD;
          end
        end else begin
          scan_nxt  = scan_inc;
          state_nxt = S_RD;
        end
      end
      S_SHRD: begin
        if (scan_inc < count_r) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = scan_inc[IDX_W-1:0];
          state_nxt     = S_SHWR;
        end else begin
          count_nxt  = count_r - CNT_W'(1);
          status_nxt = ST_REMOVED;
          state_nxt  = S_RESP;
        end
      end
      S_SHWR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = scan_r[IDX_W-1:0];
        mem_req.wdata = mem_rd_data;
        scan_nxt      = scan_inc;
        state_nxt     = S_SHRD;
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_occ_nxt    = OCC_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_r       <= scan_nxt;
    op_r         <= op_nxt;
    id_r         <= id_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

endmodule

`default_nettype wire

[hdl/ordered_slot_list_insert_remove.sv]
// Ordered slot list top level, one status word out per event; uses osl_pkg,
// osl_slot_mem and osl_ctrl. A full reject goes straight to the result register;
// else each held slot is read and compared in turn, a hit ends the search, and a
// removal then moves every later slot down by one. One word is in work at a time;
// the next is taken once the result is registered. Reset clears the count and the
// result valid flag; slots stay undefined until written.
`default_nettype none
`include "ordered_slot_list_insert_remove_defines.svh"

module ordered_slot_list_insert_remove
  import osl_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_operation,
  input  wire logic [ID_W-1:0]     in_item_id,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [OCC_W-1:0]         out_occupancy
);

  mem_req_t        mem_req;
  logic [ID_W-1:0] mem_rd_data;

  osl_slot_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  osl_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_item_id    (in_item_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_occupancy (out_occupancy),
    .mem_req       (mem_req),
    .mem_rd_data   (mem_rd_data)
  );

  `OSL_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")
  `OSL_ASSERT_NOW(a_status_code, out_valid, out_status <= ST_ABSENT, "status out of range")
  `OSL_ASSERT_NOW(a_full_occ, out_valid && out_status == ST_FULL, out_occupancy == OCC_W'(CAPACITY), "full reject")

endmodule

`default_nettype wire

[tb/tb_ordered_slot_list_insert_remove.sv]
// Self-checking testbench for ordered_slot_list_insert_remove: arrival and departure
// words go in, and each status word is checked against an in-bench model of the list.
// Depends on osl_pkg and the block's RTL only.
`default_nettype none

module tb_ordered_slot_list_insert_remove;
  timeunit 1ns;
  timeprecision 1ps;

  import osl_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [OCC_W-1:0] occupancy;
  } list_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_operation = OP_DEPART;
  logic [ID_W-1:0]     in_item_id = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [OCC_W-1:0]    out_occupancy;

  logic [ID_W-1:0] held_ids[$];
  list_result_t    expected_results[$];
  int              mismatch_count = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;

  ordered_slot_list_insert_remove dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_item_id    (in_item_id),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic list_result_t apply_event(input logic op, input logic [ID_W-1:0] id);
    list_result_t r;
    int           pos;
    pos = -1;
    foreach (held_ids[i]) begin
      if (pos < 0 && held_ids[i] == id) pos = i;
    end
    if (op == OP_ARRIVE) begin
      if (held_ids.size() >= CAPACITY) begin
        r.status = ST_FULL;
      end else if (pos >= 0) begin
        r.status = ST_PRESENT;
      end else begin
        held_ids.push_back(id);
        r.status = ST_STORED;
      end
    end else if (pos >= 0) begin
      held_ids.delete(pos);
      r.status = ST_REMOVED;
    end else begin
      r.status = ST_ABSENT;
    end
    r.occupancy = OCC_W'(held_ids.size());
    return r;
  endfunction

  task automatic send_word(input logic op, input logic [ID_W-1:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_item_id   <= id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(apply_event(op, id));
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected word: status %0d occupancy %0d", out_status, out_occupancy);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", want.occupancy, out_occupancy);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_empty_and_extremes();
    send_word(OP_DEPART, 16'h1234);
    send_word(OP_ARRIVE, 16'h0000);
    send_word(OP_ARRIVE, 16'hFFFF);
    send_word(OP_ARRIVE, 16'h0000);
  endtask

  // A full list rejects even an identifier it already holds.
  task automatic test_full_list();
    send_word(OP_ARRIVE, 16'h0001);
    send_word(OP_ARRIVE, 16'h8000);
    send_word(OP_ARRIVE, 16'h5555);
    send_word(OP_ARRIVE, 16'hAAAA);
    send_word(OP_ARRIVE, 16'h00FF);
    send_word(OP_ARRIVE, 16'hFF00);
    send_word(OP_ARRIVE, 16'hFFFF);
    send_word(OP_ARRIVE, 16'h7777);
  endtask

  task automatic test_compaction();
    send_word(OP_DEPART, 16'h5555);
    send_word(OP_DEPART, 16'h0000);
    send_word(OP_DEPART, 16'hFF00);
    send_word(OP_DEPART, 16'h5555);
    send_word(OP_ARRIVE, 16'h5555);
    send_word(OP_DEPART, 16'hFFFF);
    send_word(OP_ARRIVE, 16'h0000);
  endtask

  // Identifiers mostly come from a small pool so that duplicates, full lists
  // and hits at every position are frequent; the rest span all 16 bits.
  task automatic test_random_traffic(input int n_words);
    logic            op;
    logic [ID_W-1:0] id;
    int              arrive_pct;
    for (int n = 0; n < n_words; n++) begin
      arrive_pct = (held_ids.size() >= CAPACITY) ? 35 : 60;
      op = ($urandom_range(99) < arrive_pct) ? OP_ARRIVE : OP_DEPART;
      if (op == OP_DEPART && held_ids.size() != 0 && $urandom_range(99) < 65) begin
        id = held_ids[$urandom_range(held_ids.size() - 1)];
      end else if ($urandom_range(99) < 75) begin
        id = {$urandom_range(1) ? 4'hC : 4'h3, 8'h5A, 4'($urandom_range(11))};
      end else begin
        id = ID_W'($urandom_range(16'hFFFF));
      end
      send_word(op, id);
      if ($urandom_range(99) < 2) wait_until_drained();
    end
  endtask

  initial begin
    send_idle_pct = 27;
    recv_idle_pct = 74;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_extremes();
    test_full_list();
    test_compaction();
    wait_until_drained();
    test_random_traffic(400);
    wait_until_drained();

    send_idle_pct = 74;
    recv_idle_pct = 27;
    test_random_traffic(400);
    wait_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(400);

    in_valid <= 1'b0;
    for (int c = 0; c < 20000 && expected_results.size() != 0; c++) @(posedge clk);
    repeat (4 * CAPACITY + 16) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected words never arrived", expected_results.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire
